FILE: hdl/aslk_pkg.sv
// Shared types and codes for the arming safety interlock.
package aslk_pkg;

  localparam logic [1:0] ACTION_TICK = 2'd0;
  localparam logic [1:0] ACTION_HB   = 2'd1;
  localparam logic [1:0] ACTION_CMD  = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_HB   = 2'd2;
  localparam logic [1:0] KIND_CMD  = 2'd3;

  localparam logic [2:0] CMD_ARM         = 3'd0;
  localparam logic [2:0] CMD_DISARM      = 3'd1;
  localparam logic [2:0] CMD_START       = 3'd2;
  localparam logic [2:0] CMD_STOP        = 3'd3;
  localparam logic [2:0] CMD_ESTOP       = 3'd4;
  localparam logic [2:0] CMD_CLEAR_ESTOP = 3'd5;

  localparam logic [1:0] MODE_DISARMED = 2'd0;
  localparam logic [1:0] MODE_ARMED    = 2'd1;
  localparam logic [1:0] MODE_RUNNING  = 2'd2;
  localparam logic [1:0] MODE_ESTOP    = 2'd3;

  localparam logic [1:0] CAUSE_NONE      = 2'd0;
  localparam logic [1:0] CAUSE_STOP      = 2'd1;
  localparam logic [1:0] CAUSE_ESTOP     = 2'd2;
  localparam logic [1:0] CAUSE_HEARTBEAT = 2'd3;

  localparam logic [2:0] REASON_NONE          = 3'd0;
  localparam logic [2:0] REASON_NOT_IN_ESTOP  = 3'd1;
  localparam logic [2:0] REASON_IN_ESTOP      = 3'd2;
  localparam logic [2:0] REASON_ARM_REFUSED   = 3'd3;
  localparam logic [2:0] REASON_START_REFUSED = 3'd4;
  localparam logic [2:0] REASON_UNKNOWN       = 3'd5;
  localparam logic [2:0] REASON_MISMATCH      = 3'd6;

  localparam logic        DISP_APPLIED   = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [2:0]  cmd_type;
    logic        mismatch;
    logic [31:0] command_id;
  } entry_t;

  typedef struct packed {
    logic        ack_valid;
    logic [31:0] ack_command_id;
    logic [2:0]  ack_command_type;
    logic        ack_disposition;
    logic [2:0]  ack_reason;
    logic [1:0]  safety_state;
    logic [1:0]  halt_cause;
    logic        running;
    logic        heartbeat_fresh;
    logic [31:0] heartbeat_age_ms;
    logic        failsafe_tripped;
  } result_t;

endpackage

FILE: hdl/aslk_front.sv
// Front end: classify each incoming event into a queue entry.
module aslk_front (
  input  logic [1:0]       in_action,
  input  logic [31:0]      in_now_ms,
  input  logic [2:0]       in_frame_type,
  input  logic [2:0]       in_payload_type,
  input  logic             in_length_ok,
  input  logic [31:0]      in_command_id,
  output aslk_pkg::entry_t entry
);

  always_comb begin
    entry            = '0;
    entry.now_ms     = in_now_ms;
    entry.cmd_type   = in_frame_type;
    entry.command_id = in_command_id;
    entry.mismatch   = (in_payload_type != in_frame_type);
    case (in_action)
      aslk_pkg::ACTION_TICK: entry.kind = aslk_pkg::KIND_TICK;
      aslk_pkg::ACTION_HB: begin
        entry.kind = in_length_ok ? aslk_pkg::KIND_HB : aslk_pkg::KIND_NONE;
      end
      aslk_pkg::ACTION_CMD: begin
        entry.kind = (in_length_ok && (in_frame_type <= aslk_pkg::CMD_CLEAR_ESTOP)) ?
                     aslk_pkg::KIND_CMD : aslk_pkg::KIND_NONE;
      end
      default: entry.kind = aslk_pkg::KIND_NONE;
    endcase
  end

endmodule

FILE: hdl/aslk_queue.sv
// Short FIFO of classified events between front and back.
module aslk_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aslk_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output aslk_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  aslk_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/aslk_back.sv
// Back end: interlock state machine, heartbeat tracking and result register.
module aslk_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  aslk_pkg::entry_t  q_head,
  output logic              q_pop,
  input  logic [15:0]       timeout_ms,
  output logic              res_valid,
  input  logic              res_ready,
  output aslk_pkg::result_t res
);

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  cause_r, cause_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] last_r, last_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] age_r, age_nxt;
  logic        latch_r, latch_nxt;
  logic        res_valid_r, res_valid_nxt;
  aslk_pkg::result_t res_r, res_nxt;
  logic [2:0]  reason;
  logic        ack;

  assign q_pop     = q_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    mode_nxt  = mode_r;
    cause_nxt = cause_r;
    seen_nxt  = seen_r;
    last_nxt  = last_r;
    ok_nxt    = ok_r;
    age_nxt   = age_r;
    latch_nxt = latch_r;
    reason    = aslk_pkg::REASON_NONE;
    ack       = 1'b0;
    case (q_head.kind)
      aslk_pkg::KIND_TICK: begin
        age_nxt = seen_r ? (q_head.now_ms - last_r) : '1;
        ok_nxt  = seen_r && (age_nxt <= {16'd0, timeout_ms});
        if ((mode_r == aslk_pkg::MODE_ARMED || mode_r == aslk_pkg::MODE_RUNNING) &&
            !ok_nxt && !latch_r) begin
          latch_nxt = 1'b1;
          mode_nxt  = aslk_pkg::MODE_DISARMED;
          cause_nxt = aslk_pkg::CAUSE_HEARTBEAT;
        end
      end
      aslk_pkg::KIND_HB: begin
        seen_nxt = 1'b1;
        last_nxt = q_head.now_ms;
      end
      aslk_pkg::KIND_CMD: begin
        ack = 1'b1;
        if (q_head.mismatch) begin
          reason = aslk_pkg::REASON_MISMATCH;
        end else begin
          case (q_head.cmd_type)
            aslk_pkg::CMD_STOP: begin
              mode_nxt  = aslk_pkg::MODE_DISARMED;
              cause_nxt = aslk_pkg::CAUSE_STOP;
            end
            aslk_pkg::CMD_ESTOP: begin
              mode_nxt  = aslk_pkg::MODE_ESTOP;
              cause_nxt = aslk_pkg::CAUSE_ESTOP;
            end
            aslk_pkg::CMD_CLEAR_ESTOP: begin
              if (mode_r != aslk_pkg::MODE_ESTOP) begin
                reason = aslk_pkg::REASON_NOT_IN_ESTOP;
              end else begin
                mode_nxt  = aslk_pkg::MODE_DISARMED;
                cause_nxt = aslk_pkg::CAUSE_NONE;
              end
            end
            aslk_pkg::CMD_DISARM: begin
              if (mode_r == aslk_pkg::MODE_ESTOP) begin
                reason = aslk_pkg::REASON_IN_ESTOP;
              end else begin
                mode_nxt  = aslk_pkg::MODE_DISARMED;
                cause_nxt = aslk_pkg::CAUSE_NONE;
              end
            end
            aslk_pkg::CMD_ARM: begin
              if (!(mode_r == aslk_pkg::MODE_DISARMED && ok_r)) begin
                reason = aslk_pkg::REASON_ARM_REFUSED;
              end else begin
                mode_nxt  = aslk_pkg::MODE_ARMED;
                cause_nxt = aslk_pkg::CAUSE_NONE;
              end
            end
            aslk_pkg::CMD_START: begin
              if (!(mode_r == aslk_pkg::MODE_ARMED && ok_r)) begin
                reason = aslk_pkg::REASON_START_REFUSED;
              end else begin
                mode_nxt  = aslk_pkg::MODE_RUNNING;
                cause_nxt = aslk_pkg::CAUSE_NONE;
              end
            end
            default: reason = aslk_pkg::REASON_UNKNOWN;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt                  = '0;
    res_nxt.ack_valid        = ack;
    res_nxt.ack_command_id   = ack ? q_head.command_id : '0;
    res_nxt.ack_command_type = ack ? q_head.cmd_type : '0;
    res_nxt.ack_disposition  = ack && (reason != aslk_pkg::REASON_NONE);
    res_nxt.ack_reason       = reason;
    res_nxt.safety_state     = mode_nxt;
    res_nxt.halt_cause       = cause_nxt;
    res_nxt.running          = (mode_nxt == aslk_pkg::MODE_RUNNING);
    res_nxt.heartbeat_fresh  = ok_nxt;
    res_nxt.heartbeat_age_ms = age_nxt;
    res_nxt.failsafe_tripped = latch_nxt;
    if (q_pop) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= aslk_pkg::MODE_DISARMED;
      cause_r     <= aslk_pkg::CAUSE_NONE;
      seen_r      <= 1'b0;
      last_r      <= '0;
      ok_r        <= 1'b0;
      age_r       <= '1;
      latch_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (q_pop) begin
        mode_r  <= mode_nxt;
        cause_r <= cause_nxt;
        seen_r  <= seen_nxt;
        last_r  <= last_nxt;
        ok_r    <= ok_nxt;
        age_r   <= age_nxt;
        latch_r <= latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: hdl/arming_safety_interlock.sv
// Top level of the arming safety interlock: front, event queue, back, config register.
//
//   channel | ports              | direction | transaction
//   --------+--------------------+-----------+-------------------------------
//   in      | in_valid/in_ready  | sink      | one event (tick, heartbeat, command)
//   out     | out_valid/out_ready| source    | one result per event
//   cfg     | cfg_valid/cfg_ready| sink      | heartbeat timeout write
//
// One event per cycle sustained while out_ready is high; an accepted event passes
// through the queue entry, then the state update that loads the result register.
// The state update in the back end is the loop that sets this rate.
// Reset is synchronous, active low: disarmed, no heartbeat, timeout 1000 ms.
// A stalled output holds the result register; the queue absorbs QUEUE_DEPTH
// further events before in_ready drops. cfg_ready is always high.
module arming_safety_interlock #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic [2:0]  in_frame_type,
  input  logic [2:0]  in_payload_type,
  input  logic        in_length_ok,
  input  logic [31:0] in_command_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ack_valid,
  output logic [31:0] out_ack_command_id,
  output logic [2:0]  out_ack_command_type,
  output logic        out_ack_disposition,
  output logic [2:0]  out_ack_reason,
  output logic [1:0]  out_safety_state,
  output logic [1:0]  out_halt_cause,
  output logic        out_running,
  output logic        out_heartbeat_fresh,
  output logic [31:0] out_heartbeat_age_ms,
  output logic        out_failsafe_tripped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_heartbeat_timeout_ms
);

  aslk_pkg::entry_t  fe_entry;
  aslk_pkg::entry_t  q_head;
  aslk_pkg::result_t res;
  logic              q_full, q_valid, q_pop;
  logic [15:0]       timeout_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= aslk_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_r <= cfg_heartbeat_timeout_ms;
    end
  end

  aslk_front u_front (
    .in_action       (in_action),
    .in_now_ms       (in_now_ms),
    .in_frame_type   (in_frame_type),
    .in_payload_type (in_payload_type),
    .in_length_ok    (in_length_ok),
    .in_command_id   (in_command_id),
    .entry           (fe_entry)
  );

  aslk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (fe_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  aslk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .timeout_ms (timeout_r),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_ack_valid        = res.ack_valid;
  assign out_ack_command_id   = res.ack_command_id;
  assign out_ack_command_type = res.ack_command_type;
  assign out_ack_disposition  = res.ack_disposition;
  assign out_ack_reason       = res.ack_reason;
  assign out_safety_state     = res.safety_state;
  assign out_halt_cause       = res.halt_cause;
  assign out_running          = res.running;
  assign out_heartbeat_fresh  = res.heartbeat_fresh;
  assign out_heartbeat_age_ms = res.heartbeat_age_ms;
  assign out_failsafe_tripped = res.failsafe_tripped;

  a_disp_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_valid |->
      (out_ack_disposition == (out_ack_reason != aslk_pkg::REASON_NONE)))
    else $error("ack disposition disagrees with reason");

  a_no_ack_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ack_valid |->
      (out_ack_reason == aslk_pkg::REASON_NONE) && !out_ack_disposition &&
      (out_ack_command_id == '0))
    else $error("ack fields set without ack");

  a_running_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_running == (out_safety_state == aslk_pkg::MODE_RUNNING)))
    else $error("running flag disagrees with safety state");

  a_hb_cause_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_halt_cause == aslk_pkg::CAUSE_HEARTBEAT) |-> out_failsafe_tripped)
    else $error("heartbeat stop without failsafe latch");

  a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_failsafe_tripped ##1 out_valid |-> out_failsafe_tripped)
    else $error("failsafe latch cleared");

endmodule

FILE: bench/arming_safety_interlock_tb.sv
// Self-checking testbench for the arming safety interlock: directed and random traffic, predictor, scoreboard.
`timescale 1ns / 1ps

module arming_safety_interlock_tb;

  localparam logic [1:0] ACTION_IDLE    = 2'd3;
  localparam logic [2:0] FRAME_OTHER    = 3'd6;
  localparam logic [2:0] FRAME_RESERVED = 3'd7;
  localparam logic       DISP_REJECTED  = 1'b1;
  localparam int         LONG_HOLD      = 60;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         CYCLE_LIMIT    = 200000;
  localparam int         MAX_REPORTS    = 60;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [2:0]  frame_type;
    logic [2:0]  payload_type;
    logic        length_ok;
    logic [31:0] command_id;
  } interlock_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [31:0] in_now_ms = '0;
  logic [2:0]  in_frame_type = '0;
  logic [2:0]  in_payload_type = '0;
  logic        in_length_ok = 1'b0;
  logic [31:0] in_command_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_ack_valid;
  logic [31:0] out_ack_command_id;
  logic [2:0]  out_ack_command_type;
  logic        out_ack_disposition;
  logic [2:0]  out_ack_reason;
  logic [1:0]  out_safety_state;
  logic [1:0]  out_halt_cause;
  logic        out_running;
  logic        out_heartbeat_fresh;
  logic [31:0] out_heartbeat_age_ms;
  logic        out_failsafe_tripped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_heartbeat_timeout_ms = '0;

  arming_safety_interlock u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_action                (in_action),
    .in_now_ms                (in_now_ms),
    .in_frame_type            (in_frame_type),
    .in_payload_type          (in_payload_type),
    .in_length_ok             (in_length_ok),
    .in_command_id            (in_command_id),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_ack_valid            (out_ack_valid),
    .out_ack_command_id       (out_ack_command_id),
    .out_ack_command_type     (out_ack_command_type),
    .out_ack_disposition      (out_ack_disposition),
    .out_ack_reason           (out_ack_reason),
    .out_safety_state         (out_safety_state),
    .out_halt_cause           (out_halt_cause),
    .out_running              (out_running),
    .out_heartbeat_fresh      (out_heartbeat_fresh),
    .out_heartbeat_age_ms     (out_heartbeat_age_ms),
    .out_failsafe_tripped     (out_failsafe_tripped),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_heartbeat_timeout_ms (cfg_heartbeat_timeout_ms)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Interlock state as the predictor sees it.
  logic [1:0]  il_mode = aslk_pkg::MODE_DISARMED;
  logic [1:0]  il_cause = aslk_pkg::CAUSE_NONE;
  logic        hb_seen = 1'b0;
  logic [31:0] hb_last_ms = '0;
  logic        hb_fresh = 1'b0;
  logic [31:0] hb_age_ms = '1;
  logic        failsafe_latched = 1'b0;
  logic [15:0] timeout_ms = aslk_pkg::TIMEOUT_RESET;

  interlock_event_t  pending_events[$];
  aslk_pkg::result_t expected_status[$];
  interlock_event_t  offered;
  aslk_pkg::result_t predicted_status;
  aslk_pkg::result_t observed_status;
  aslk_pkg::result_t wanted_status;

  int          error_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          holds_requested = 0;
  int          holds_granted = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  logic [31:0] clock_ms = '0;

  task automatic interlock_step(input interlock_event_t ev, output aslk_pkg::result_t r);
    logic       ack;
    logic [2:0] reason;
    ack = 1'b0;
    reason = aslk_pkg::REASON_NONE;
    case (ev.action)
      aslk_pkg::ACTION_TICK: begin
        hb_age_ms = hb_seen ? ev.now_ms - hb_last_ms : '1;
        hb_fresh = hb_seen && (hb_age_ms <= {16'd0, timeout_ms});
        if ((il_mode == aslk_pkg::MODE_ARMED || il_mode == aslk_pkg::MODE_RUNNING) &&
            !hb_fresh && !failsafe_latched) begin
          failsafe_latched = 1'b1;
          il_mode = aslk_pkg::MODE_DISARMED;
          il_cause = aslk_pkg::CAUSE_HEARTBEAT;
        end
      end
      aslk_pkg::ACTION_HB: begin
        if (ev.length_ok) begin
          hb_seen = 1'b1;
          hb_last_ms = ev.now_ms;
        end
      end
      aslk_pkg::ACTION_CMD: begin
        if (ev.frame_type <= aslk_pkg::CMD_CLEAR_ESTOP && ev.length_ok) begin
          ack = 1'b1;
          if (ev.payload_type != ev.frame_type) begin
            reason = aslk_pkg::REASON_MISMATCH;
          end else begin
            case (ev.frame_type)
              aslk_pkg::CMD_STOP: begin
                il_mode = aslk_pkg::MODE_DISARMED;
                il_cause = aslk_pkg::CAUSE_STOP;
              end
              aslk_pkg::CMD_ESTOP: begin
                il_mode = aslk_pkg::MODE_ESTOP;
                il_cause = aslk_pkg::CAUSE_ESTOP;
              end
              aslk_pkg::CMD_CLEAR_ESTOP: begin
                if (il_mode != aslk_pkg::MODE_ESTOP) begin
                  reason = aslk_pkg::REASON_NOT_IN_ESTOP;
                end else begin
                  il_mode = aslk_pkg::MODE_DISARMED;
                  il_cause = aslk_pkg::CAUSE_NONE;
                end
              end
              aslk_pkg::CMD_DISARM: begin
                if (il_mode == aslk_pkg::MODE_ESTOP) begin
                  reason = aslk_pkg::REASON_IN_ESTOP;
                end else begin
                  il_mode = aslk_pkg::MODE_DISARMED;
                  il_cause = aslk_pkg::CAUSE_NONE;
                end
              end
              aslk_pkg::CMD_ARM: begin
                if (!(il_mode == aslk_pkg::MODE_DISARMED && hb_fresh)) begin
                  reason = aslk_pkg::REASON_ARM_REFUSED;
                end else begin
                  il_mode = aslk_pkg::MODE_ARMED;
                  il_cause = aslk_pkg::CAUSE_NONE;
                end
              end
              aslk_pkg::CMD_START: begin
                if (!(il_mode == aslk_pkg::MODE_ARMED && hb_fresh)) begin
                  reason = aslk_pkg::REASON_START_REFUSED;
                end else begin
                  il_mode = aslk_pkg::MODE_RUNNING;
                  il_cause = aslk_pkg::CAUSE_NONE;
                end
              end
              default: begin
                reason = aslk_pkg::REASON_UNKNOWN;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
    r = '0;
    r.ack_valid = ack;
    if (ack) begin
      r.ack_command_id = ev.command_id;
      r.ack_command_type = ev.frame_type;
      r.ack_disposition = (reason != aslk_pkg::REASON_NONE) ? DISP_REJECTED :
                          aslk_pkg::DISP_APPLIED;
      r.ack_reason = reason;
    end
    r.safety_state = il_mode;
    r.halt_cause = il_cause;
    r.running = (il_mode == aslk_pkg::MODE_RUNNING);
    r.heartbeat_fresh = hb_fresh;
    r.heartbeat_age_ms = hb_age_ms;
    r.failsafe_tripped = failsafe_latched;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Driver: offer queued events, hold each one until the transaction completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        interlock_step(offered, predicted_status);
        expected_status.push_back(predicted_status);
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0 && idle_on && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          offered = pending_events.pop_front();
          in_action <= offered.action;
          in_now_ms <= offered.now_ms;
          in_frame_type <= offered.frame_type;
          in_payload_type <= offered.payload_type;
          in_length_ok <= offered.length_ok;
          in_command_id <= offered.command_id;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side flow control: short random stalls plus requested long holds.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_granted < holds_requested) begin
      holds_granted++;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed_status.ack_valid = out_ack_valid;
      observed_status.ack_command_id = out_ack_command_id;
      observed_status.ack_command_type = out_ack_command_type;
      observed_status.ack_disposition = out_ack_disposition;
      observed_status.ack_reason = out_ack_reason;
      observed_status.safety_state = out_safety_state;
      observed_status.halt_cause = out_halt_cause;
      observed_status.running = out_running;
      observed_status.heartbeat_fresh = out_heartbeat_fresh;
      observed_status.heartbeat_age_ms = out_heartbeat_age_ms;
      observed_status.failsafe_tripped = out_failsafe_tripped;
      if (expected_status.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with no prediction, expected none, actual 0x%0h",
                   $time, observed_status);
      end else begin
        wanted_status = expected_status.pop_front();
        check_field("ack_valid", wanted_status.ack_valid, observed_status.ack_valid);
        check_field("ack_command_id", wanted_status.ack_command_id,
                    observed_status.ack_command_id);
        check_field("ack_command_type", wanted_status.ack_command_type,
                    observed_status.ack_command_type);
        check_field("ack_disposition", wanted_status.ack_disposition,
                    observed_status.ack_disposition);
        check_field("ack_reason", wanted_status.ack_reason, observed_status.ack_reason);
        check_field("safety_state", wanted_status.safety_state, observed_status.safety_state);
        check_field("halt_cause", wanted_status.halt_cause, observed_status.halt_cause);
        check_field("running", wanted_status.running, observed_status.running);
        check_field("heartbeat_fresh", wanted_status.heartbeat_fresh,
                    observed_status.heartbeat_fresh);
        check_field("heartbeat_age_ms", wanted_status.heartbeat_age_ms,
                    observed_status.heartbeat_age_ms);
        check_field("failsafe_tripped", wanted_status.failsafe_tripped,
                    observed_status.failsafe_tripped);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_event(input logic [1:0] action, input logic [31:0] now,
                             input logic [2:0] ftype, input logic [2:0] ptype,
                             input logic len_ok, input logic [31:0] id);
    interlock_event_t ev;
    ev.action = action;
    ev.now_ms = now;
    ev.frame_type = ftype;
    ev.payload_type = ptype;
    ev.length_ok = len_ok;
    ev.command_id = id;
    pending_events.push_back(ev);
  endtask

  task automatic queue_command(input logic [2:0] ctype, input logic [31:0] id);
    queue_event(aslk_pkg::ACTION_CMD, $urandom, ctype, ctype, 1'b1, id);
  endtask

  // Random traffic: arm/start sessions around fresh heartbeats, mixed with loose events.
  task automatic queue_random(input int count);
    int               sel;
    logic [31:0]      step;
    interlock_event_t ev;
    while (count > 0) begin
      if ($urandom_range(0, 5) == 0) begin
        clock_ms += $urandom_range(0, 2 * int'(timeout_ms) + 2);
        queue_event(aslk_pkg::ACTION_HB, clock_ms, 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), 1'b1, $urandom);
        clock_ms += $urandom_range(0, int'(timeout_ms));
        queue_event(aslk_pkg::ACTION_TICK, clock_ms, 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom);
        queue_command(aslk_pkg::CMD_ARM, $urandom);
        queue_command(aslk_pkg::CMD_START, $urandom);
        count -= 4;
      end else begin
        sel = $urandom_range(0, 99);
        step = $urandom_range(0, 2 * int'(timeout_ms) + 2);
        if ($urandom_range(0, 49) == 0)
          clock_ms = $urandom;
        else
          clock_ms += step;
        ev.now_ms = clock_ms;
        ev.frame_type = 3'($urandom_range(0, 7));
        ev.payload_type = 3'($urandom_range(0, 7));
        ev.length_ok = 1'($urandom_range(0, 1));
        ev.command_id = $urandom;
        if (sel < 35) begin
          ev.action = aslk_pkg::ACTION_TICK;
        end else if (sel < 60) begin
          ev.action = aslk_pkg::ACTION_HB;
          ev.length_ok = ($urandom_range(0, 9) != 0);
        end else if (sel < 96) begin
          ev.action = aslk_pkg::ACTION_CMD;
          if ($urandom_range(0, 9) != 0)
            ev.frame_type = 3'($urandom_range(aslk_pkg::CMD_ARM,
                                              aslk_pkg::CMD_CLEAR_ESTOP));
          if ($urandom_range(0, 6) != 0)
            ev.payload_type = ev.frame_type;
          ev.length_ok = ($urandom_range(0, 19) != 0);
        end else begin
          ev.action = ACTION_IDLE;
        end
        pending_events.push_back(ev);
        count--;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || out_valid ||
           expected_status.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk);
    cfg_heartbeat_timeout_ms <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    timeout_ms = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_event(aslk_pkg::ACTION_TICK, 32'h0, aslk_pkg::CMD_ARM, aslk_pkg::CMD_ARM, 1'b0,
                32'h0);
    queue_command(aslk_pkg::CMD_ARM, 32'hFFFF_FFFF);
    queue_command(aslk_pkg::CMD_START, 32'h0);
    queue_command(aslk_pkg::CMD_CLEAR_ESTOP, 32'h11);
    queue_command(aslk_pkg::CMD_DISARM, 32'h12);
    queue_event(aslk_pkg::ACTION_HB, 32'd100, FRAME_RESERVED, FRAME_RESERVED, 1'b0, 32'h13);
    queue_event(aslk_pkg::ACTION_HB, 32'd100, aslk_pkg::CMD_ARM, aslk_pkg::CMD_ARM, 1'b1,
                32'h14);
    queue_event(aslk_pkg::ACTION_TICK, 32'd1100, aslk_pkg::CMD_ARM, aslk_pkg::CMD_ARM, 1'b1,
                32'h15);
    queue_command(aslk_pkg::CMD_ARM, 32'h16);
    queue_command(aslk_pkg::CMD_START, 32'h17);
    queue_event(aslk_pkg::ACTION_CMD, 32'd1100, aslk_pkg::CMD_STOP, FRAME_RESERVED, 1'b1,
                32'h18);
    queue_event(aslk_pkg::ACTION_CMD, 32'd1100, FRAME_OTHER, FRAME_OTHER, 1'b1, 32'h19);
    queue_event(aslk_pkg::ACTION_CMD, 32'd1100, FRAME_RESERVED, FRAME_RESERVED, 1'b1,
                32'h1A);
    queue_event(aslk_pkg::ACTION_CMD, 32'd1100, aslk_pkg::CMD_STOP, aslk_pkg::CMD_STOP,
                1'b0, 32'h1B);
    queue_event(ACTION_IDLE, 32'hFFFF_FFFF, FRAME_RESERVED, FRAME_RESERVED, 1'b1,
                32'hFFFF_FFFF);
    queue_event(aslk_pkg::ACTION_TICK, 32'd1101, aslk_pkg::CMD_ARM, aslk_pkg::CMD_ARM, 1'b1,
                32'h1C);
    queue_event(aslk_pkg::ACTION_HB, 32'hFFFF_FF00, aslk_pkg::CMD_ARM, aslk_pkg::CMD_ARM,
                1'b1, 32'h1D);
    queue_event(aslk_pkg::ACTION_TICK, 32'h0000_0010, aslk_pkg::CMD_ARM, aslk_pkg::CMD_ARM,
                1'b1, 32'h1E);
    queue_command(aslk_pkg::CMD_ARM, 32'h1F);
    queue_event(aslk_pkg::ACTION_TICK, 32'h0010_0000, aslk_pkg::CMD_ARM, aslk_pkg::CMD_ARM,
                1'b1, 32'h20);
    queue_command(aslk_pkg::CMD_START, 32'h21);
    queue_command(aslk_pkg::CMD_ESTOP, 32'h22);
    queue_command(aslk_pkg::CMD_DISARM, 32'h23);
    queue_command(aslk_pkg::CMD_ARM, 32'h24);
    queue_command(aslk_pkg::CMD_STOP, 32'h25);
    queue_command(aslk_pkg::CMD_ESTOP, 32'h26);
    queue_command(aslk_pkg::CMD_CLEAR_ESTOP, 32'h27);
    wait_drained();

    write_timeout(16'd0);
    queue_random(150);
    wait_drained();

    write_timeout(16'hFFFF);
    queue_random(150);
    holds_requested++;
    wait_drained();

    write_timeout(16'($urandom_range(2, 65534)));
    queue_random(75);
    wait_drained();
    queue_random(75);
    wait_drained();

    write_timeout(16'd1);
    queue_random(150);
    wait_drained();

    write_timeout(16'($urandom_range(0, 3000)));
    queue_random(150);
    wait_drained();

    idle_on = 1'b0;
    write_timeout(aslk_pkg::TIMEOUT_RESET);
    queue_random(150);
    wait_drained();

    if (error_count == 0 && expected_status.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
